// ===== sv/atm_epd_pkg.sv =====
// Shared types and constants for the ATM EPD cell admission block.
`default_nettype none
package atm_epd_pkg;

  localparam int VC_COUNT = 1024;
  localparam int VC_W     = (VC_COUNT > 1) ? $clog2(VC_COUNT) : 1;
  localparam int CNT_W    = 16;
  localparam int VCI_W    = 16;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    FN_AAL5  = 2'd0,
    FN_CBR   = 2'd1,
    FN_SERVE = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STS_QUEUED   = 3'd0,
    STS_EPD      = 3'd1,
    STS_OVERFLOW = 3'd2,
    STS_ILLEGAL  = 3'd3,
    STS_SERVICE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FROM_NONE = 2'd0,
    FROM_CBR  = 2'd1,
    FROM_AAL5 = 2'd2
  } from_t;

  typedef enum logic [1:0] {
    CFG_EPD_THRESHOLD = 2'd0,
    CFG_AAL5_CAPACITY = 2'd1,
    CFG_CBR_CAPACITY  = 2'd2,
    CFG_PASS_EOF      = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW
  } state_t;

  localparam logic [15:0] RST_EPD_THRESHOLD = 16'd600;
  localparam logic [15:0] RST_AAL5_CAPACITY = 16'd1000;
  localparam logic [15:0] RST_CBR_CAPACITY  = 16'd100;

endpackage
`default_nettype wire

// ===== sv/atm_epd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module atm_epd_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/atm_epd_cell_admission_core.sv =====
// Top level of the ATM cell admission block with early packet discard.
//
// Input channel in_*: in_tuser[1:0] carries the function (AAL5 arrival,
// non-AAL5 arrival, service), in_tdata[15:0] the VCI and in_tlast the
// end-of-frame bit of an AAL5 cell. Result channel out_*: out_tuser the
// status code, out_tdata the served queue and both queue occupancies.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata.
//
// Each item passes through ST_IDLE and ST_RMW: the per-VC frame state
// RAM is read in the accept cycle and written back in ST_RMW, where the
// result is loaded into the output register; ST_RMW waits while a held
// result is not taken. A new item is accepted only once ST_RMW is left.
// A function code of three is consumed and produces no result.
//
// After reset the frame state RAM is swept to "frame start, accepted",
// one entry a cycle, over all VC_COUNT entries; in_tready stays low
// meanwhile. A stalled receiver holds the result in the output register;
// one further item may be accepted and waits for the register to drain.
`default_nettype none
module atm_epd_cell_admission_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // vci
  input  wire logic [1:0]  in_tuser,   // func
  input  wire logic        in_tlast,   // end_of_frame
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // served_from[1:0], aal5_length[17:2],
                                       // cbr_length[33:18], zero fill
  output logic [2:0]       out_tuser,  // status
  input  wire logic        cfg_we,
  input  wire atm_epd_pkg::cfg_index_t cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import atm_epd_pkg::*;

  state_t state_r, state_nxt;
  logic [VC_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [15:0] epd_threshold_r, aal5_capacity_r, cbr_capacity_r;
  logic        pass_eof_r;

  logic [CNT_W-1:0] aal5_count_r, aal5_count_nxt;
  logic [CNT_W-1:0] cbr_count_r, cbr_count_nxt;

  func_t            func_r;
  logic [VCI_W-1:0] vci_r;
  logic             eof_r;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, status_nxt;
  from_t            out_from_r, from_nxt;
  logic [CNT_W-1:0] out_aal5_r, out_cbr_r;

  logic            ram_we;
  logic [VC_W-1:0] ram_waddr;
  logic [1:0]      ram_wdata;
  logic [1:0]      ram_rdata;
  logic            in_accept;
  logic            go;
  logic            vci_ok;
  logic            fs_nxt, fa_nxt;
  logic            st_we;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign go        = !out_valid_r || out_tready;
  assign vci_ok    = ({1'b0, vci_r} < 17'(VC_COUNT));

  atm_epd_ram #(
    .WIDTH (2),
    .DEPTH (VC_COUNT)
  ) u_vc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (in_tdata[VC_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epd_threshold_r <= RST_EPD_THRESHOLD;
      aal5_capacity_r <= RST_AAL5_CAPACITY;
      cbr_capacity_r  <= RST_CBR_CAPACITY;
      pass_eof_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EPD_THRESHOLD: epd_threshold_r <= cfg_wdata;
        CFG_AAL5_CAPACITY: aal5_capacity_r <= cfg_wdata;
        CFG_CBR_CAPACITY:  cbr_capacity_r  <= cfg_wdata;
        CFG_PASS_EOF:      pass_eof_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    aal5_count_nxt = aal5_count_r;
    cbr_count_nxt  = cbr_count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    status_nxt     = STS_QUEUED;
    from_nxt       = FROM_NONE;
    fs_nxt         = ram_rdata[1];
    fa_nxt         = ram_rdata[0];
    st_we          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = vci_r[VC_W-1:0];
    ram_wdata      = {fs_nxt, fa_nxt};
    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = 2'b11;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == VC_W'(VC_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_RMW;
        end
      end
      ST_RMW: begin
        if (go) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = (func_r != FN_NOP);
          case (func_r)
            FN_SERVE: begin
              status_nxt = STS_SERVICE;
              if (cbr_count_r != '0) begin
                cbr_count_nxt = cbr_count_r - 1'b1;
                from_nxt      = FROM_CBR;
              end else if (aal5_count_r != '0) begin
                aal5_count_nxt = aal5_count_r - 1'b1;
                from_nxt       = FROM_AAL5;
              end
            end
            FN_CBR: begin
              if (cbr_count_r < cbr_capacity_r) begin
                cbr_count_nxt = cbr_count_r + 1'b1;
                status_nxt    = STS_QUEUED;
              end else begin
                status_nxt = STS_OVERFLOW;
              end
            end
            FN_AAL5: begin
              if (!vci_ok) begin
                status_nxt = STS_ILLEGAL;
              end else begin
                st_we = 1'b1;
                if (ram_rdata[1]) begin
                  fs_nxt = 1'b0;
                  fa_nxt = (aal5_count_r < epd_threshold_r);
                end
                if (eof_r) begin
                  fs_nxt = 1'b1;
                  if (pass_eof_r || fa_nxt) begin
                    if (aal5_count_r < aal5_capacity_r) begin
                      aal5_count_nxt = aal5_count_r + 1'b1;
                      status_nxt     = STS_QUEUED;
                    end else begin
                      status_nxt = STS_OVERFLOW;
                    end
                  end else begin
                    status_nxt = STS_EPD;
                  end
                end else if (fa_nxt) begin
                  if (aal5_count_r < aal5_capacity_r) begin
                    aal5_count_nxt = aal5_count_r + 1'b1;
                    status_nxt     = STS_QUEUED;
                  end else begin
                    status_nxt = STS_OVERFLOW;
                    fa_nxt     = 1'b0;
                  end
                end else begin
                  status_nxt = STS_EPD;
                end
                ram_we    = st_we;
                ram_wdata = {fs_nxt, fa_nxt};
              end
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      aal5_count_r <= '0;
      cbr_count_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      aal5_count_r <= aal5_count_nxt;
      cbr_count_r  <= cbr_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r <= func_t'(in_tuser);
      vci_r  <= in_tdata;
      eof_r  <= in_tlast;
    end
    if (state_r == ST_RMW && go) begin
      out_status_r <= status_nxt;
      out_from_r   <= from_nxt;
      out_aal5_r   <= aal5_count_nxt;
      out_cbr_r    <= cbr_count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'd0, out_cbr_r, out_aal5_r, out_from_r};

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_tvalid)
    else $error("result presented during frame state sweep");

  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RMW && go && func_r != FN_NOP) |=> out_tvalid)
    else $error("processed item gave no result");

  a_from_only_on_service: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != STS_SERVICE) |-> out_tdata[1:0] == FROM_NONE)
    else $error("served queue set on an arrival");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RMW && !go) |=> !in_tready)
    else $error("input taken while an item is held");

endmodule
`default_nettype wire
